// ----- src/ita_pkg.sv -----
// Shared constants, types and helper functions for the integer to ASCII converter.
// Used by ita_cell and integer_to_ascii_radix; depends on nothing else.
package ita_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 7;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

	localparam logic [RADIX_W-1:0] DEC_BASE = 5'd10;
	localparam logic [RADIX_W-1:0] MIN_BASE = 5'd2;
	localparam logic [RADIX_W-1:0] MAX_BASE = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = DEC_BASE;

	// Control handed to every digit cell.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	// Clamp the radix register into the supported range of bases.
	function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		b = r;
		if (r < MIN_BASE) begin
			b = MIN_BASE;
		end else if (r > MAX_BASE) begin
			b = MAX_BASE;
		end
		return b;
	endfunction

	// ASCII code of one digit: 0-9 then A-F.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_W'(DEC_BASE)) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d) - CHAR_W'(DEC_BASE);
		end
		return c;
	endfunction

endpackage

// ----- src/ita_cell.sv -----
// One digit cell of the conversion row: doubles its digit and adds the carry from below.
// Depends on ita_pkg.
module ita_cell import ita_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctrl_t          ctrl,
	input  logic [RADIX_W-1:0]  base,
	input  logic                step_in,
	input  logic                carry_in,
	input  logic [DIGIT_W-1:0]  digit_in,
	output logic                step_out,
	output logic                carry_out,
	output logic [DIGIT_W-1:0]  digit_out
);

	logic [DIGIT_W-1:0] digit_q;
	logic               carry_q;
	logic               step_q;
	logic [RADIX_W-1:0] dbl;

	// Twice the digit plus the incoming carry stays below twice the base.
	assign dbl = {digit_q, carry_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			carry_q <= 1'b0;
			step_q  <= 1'b0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
			carry_q <= 1'b0;
			step_q  <= 1'b0;
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
			step_q  <= 1'b0;
		end else begin
			step_q <= step_in;
			if (step_in) begin
				if (dbl >= base) begin
					digit_q <= DIGIT_W'(dbl - base);
					carry_q <= 1'b1;
				end else begin
					digit_q <= DIGIT_W'(dbl);
					carry_q <= 1'b0;
				end
			end
		end
	end

	assign step_out  = step_q;
	assign carry_out = carry_q;
	assign digit_out = digit_q;

endmodule

// ----- src/integer_to_ascii_radix.sv -----
// Integer to ASCII converter, radix 2 to 16, top level. Depends on ita_pkg and ita_cell.
// The first character, a minus sign or the leading digit, is offered once the
// conversion wave has finished; each suppressed leading zero delays the first digit,
// and a minus sign is offered ahead of the digits and delays them further.
// A new value is accepted only in the idle state, so the block takes no new item until
// the skewed carry wave through the digit row and the serial shift out of all digits
// are through; output stalls hold the block longer.
// Reset: radix returns to 10, the block is idle and no result is offered.
module integer_to_ascii_radix import ita_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int S_DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input stream. tdata: value[VALUE_BITS-1:0], zero padding above.
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// Output stream. tdata: character[6:0], zero in bit 7. tlast: last.
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic                m_axis_tlast,
	// Radix register write port.
	input  logic                cfg_we,
	input  logic [RADIX_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(2 * VALUE_BITS);
	localparam int EMIT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] FEED_END = CNT_W'(VALUE_BITS);
	localparam logic [CNT_W-1:0] CONV_END = CNT_W'(2 * VALUE_BITS - 2);
	localparam logic [EMIT_W-1:0] EMIT_LAST = EMIT_W'(VALUE_BITS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SIGN, ST_EMIT} state_t;

	state_t                  state_q;
	logic [RADIX_W-1:0]      radix_q;
	logic [RADIX_W-1:0]      base_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [CNT_W-1:0]        conv_cnt_q;
	logic [EMIT_W-1:0]       emit_cnt_q;
	logic                    lead_q;
	logic                    m_valid_q;
	logic [CHAR_W-1:0]       m_char_q;
	logic                    m_last_q;

	logic [VALUE_BITS-1:0]   in_value;
	logic                    in_fire;
	logic [RADIX_W-1:0]      in_base;
	logic                    in_minus;
	logic                    out_free;
	logic                    out_load;
	logic                    emit_take;
	logic                    emit_show;
	cell_ctrl_t              cell_ctrl;

	logic                    step_w  [VALUE_BITS];
	logic                    carry_w [VALUE_BITS];
	logic [DIGIT_W-1:0]      digit_w [VALUE_BITS];
	logic [DIGIT_W-1:0]      top_digit;

	assign in_value = s_axis_tdata[VALUE_BITS-1:0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign in_base = eff_base(radix_q);
	// Only base ten shows a sign; other bases convert the raw bit pattern.
	assign in_minus = in_value[VALUE_BITS-1] && (in_base == DEC_BASE);

	// The output register can take a new character when empty or being drained.
	assign out_free = !m_valid_q || m_axis_tready;
	assign top_digit = digit_w[VALUE_BITS-1];
	assign emit_take = (state_q == ST_EMIT) && out_free;
	// Leading zeros are shifted out silently, except the final digit so zero prints "0".
	assign emit_show = emit_take &&
		!(lead_q && (top_digit == '0) && (emit_cnt_q != EMIT_LAST));
	// A new character enters the output register: the minus sign or a shown digit.
	assign out_load = ((state_q == ST_SIGN) && out_free) || emit_show;

	assign cell_ctrl.clear = in_fire;
	assign cell_ctrl.shift = emit_take;

	// The digit row, least significant digit in cell 0. During conversion the value's
	// bits enter cell 0 most significant first; each cell doubles its digit modulo the
	// base and passes the overflow one cell up through its carry register, so a carry
	// wave sweeps the row. During output the row shifts up one cell per digit taken.
	for (genvar k = 0; k < VALUE_BITS; k++) begin : g_cell
		if (k == 0) begin : g_first
			ita_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.base     (base_q),
				.step_in  ((state_q == ST_CONV) && (conv_cnt_q < FEED_END)),
				.carry_in (val_q[VALUE_BITS-1]),
				.digit_in ('0),
				.step_out (step_w[k]),
				.carry_out(carry_w[k]),
				.digit_out(digit_w[k])
			);
		end else begin : g_next
			ita_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.base     (base_q),
				.step_in  (step_w[k-1]),
				.carry_in (carry_w[k-1]),
				.digit_in (digit_w[k-1]),
				.step_out (step_w[k]),
				.carry_out(carry_w[k]),
				.digit_out(digit_w[k])
			);
		end
	end

	// Sequencer: capture, conversion wave, optional sign, then serial digit output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			radix_q    <= RADIX_RESET;
			base_q     <= DEC_BASE;
			val_q      <= '0;
			conv_cnt_q <= '0;
			emit_cnt_q <= '0;
			lead_q     <= 1'b1;
			m_valid_q  <= 1'b0;
			m_char_q   <= '0;
			m_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// Negation wraps, so the most negative value becomes 2^(VALUE_BITS-1).
						val_q      <= in_minus ? VALUE_BITS'(-in_value) : in_value;
						base_q     <= in_base;
						lead_q     <= in_minus;
						conv_cnt_q <= '0;
						state_q    <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_cnt_q < FEED_END) begin
						val_q <= val_q << 1;
					end
					conv_cnt_q <= conv_cnt_q + 1'b1;
					if (conv_cnt_q == CONV_END) begin
						emit_cnt_q <= '0;
						lead_q     <= 1'b1;
						// lead_q held the sign flag through the conversion.
						state_q    <= lead_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						m_char_q  <= CHAR_MINUS;
						m_last_q  <= 1'b0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_take) begin
						emit_cnt_q <= emit_cnt_q + 1'b1;
						if (emit_show) begin
							m_char_q  <= digit_char(top_digit);
							m_last_q  <= (emit_cnt_q == EMIT_LAST);
							lead_q    <= 1'b0;
						end
						if (emit_cnt_q == EMIT_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_char_q};
	assign m_axis_tlast  = m_last_q;

endmodule
